/* rtl/slot_table_first_fit_allocator_core_macros.svh */
// Assertion macros used by the slot table allocator engine.
`ifndef SLOT_TABLE_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define SLOT_TABLE_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH

// Checked at every clock edge, also while reset is asserted.
`define STFFA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define STFFA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/stffa_pkg.sv */
// Types and constants shared by the slot table allocator modules.
`default_nettype none

package stffa_pkg;

    localparam int OWNER_W   = 9;
    localparam int SLOTS_W   = 9;
    localparam int REQ_W     = 2;
    localparam int COUNT_W   = 5;
    localparam int SIDX_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int GSLOT_W   = 8;
    localparam int RELCNT_W  = 9;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // Width used to compare a request count against the largest request size.
    localparam int CNT_CMP_W = 7;

    localparam logic [SLOTS_W-1:0]  SLOTS_RESET = 9'd256;
    localparam logic [RELCNT_W-1:0] RELCNT_MAX  = 9'd511;

    // Register select taken from paddr[2].
    localparam logic REG_ALLOC_MODE   = 1'b0;
    localparam logic REG_SLOTS_IN_USE = 1'b1;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_ALLOC     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REL_OWNER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REL_SLOT  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_GRANT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAIL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REL   = 2'd2;

    typedef struct packed {
        logic               alloc_mode;
        logic [SLOTS_W-1:0] slots_in_use;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/slot_table_first_fit_allocator_core.sv */
// Allocate scans the slot table until enough free slots are found (or the whole managed
// table when nothing fits), then reads the found list and grants each slot in turn.
// Release by owner scans the whole managed table; release of one slot reads one entry.
// One request at a time; the single read port of the slot table RAM, one slot per cycle,
// sets the scan time.
// Reset: state and valid registers clear at once, then a clearing pass writes NUM_SLOTS free
// entries, one per cycle, with s_axis_tready low; configuration writes are taken throughout.
`default_nettype none

module slot_table_first_fit_allocator_core #(
    parameter int NUM_SLOTS   = 256,
    parameter int MAX_REQUEST = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [stffa_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [stffa_pkg::PDATA_W-1:0]     pwdata,
    output logic [stffa_pkg::PDATA_W-1:0]          prdata,
    output logic                                   pready,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // owner_id[8:0], count[13:9], slot_index[21:14], zero fill
    input  wire logic [stffa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type[1:0]
    input  wire logic [stffa_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // granted_slot[7:0], released_count[16:8], zero fill
    output logic [stffa_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // status[1:0]
    output logic [stffa_pkg::STATUS_W-1:0]         m_axis_tuser,
    output logic                                   m_axis_tlast
);

    stffa_pkg::cfg_t                   cfg;
    logic [stffa_pkg::GSLOT_W-1:0]     res_slot;
    logic [stffa_pkg::RELCNT_W-1:0]    res_count;

    stffa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stffa_engine #(
        .NUM_SLOTS   (NUM_SLOTS),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (s_axis_tuser),
        .in_owner   (s_axis_tdata[8:0]),
        .in_count   (s_axis_tdata[13:9]),
        .in_slot    (s_axis_tdata[21:14]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_slot   (res_slot),
        .out_count  (res_count),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {
        {(stffa_pkg::OUT_DATA_W - stffa_pkg::GSLOT_W - stffa_pkg::RELCNT_W){1'b0}},
        res_count,
        res_slot
    };

endmodule

`default_nettype wire

/* rtl/stffa_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module stffa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/stffa_cfg.sv */
// APB register file holding the allocation mode and the managed table size.
`default_nettype none

module stffa_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [stffa_pkg::PADDR_W-1:0] paddr,
    input  wire logic [stffa_pkg::PDATA_W-1:0] pwdata,
    output logic [stffa_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready,
    output stffa_pkg::cfg_t                    cfg
);

    logic                             alloc_mode_reg;
    logic                             alloc_mode_next;
    logic [stffa_pkg::SLOTS_W-1:0]    slots_reg;
    logic [stffa_pkg::SLOTS_W-1:0]    slots_next;
    logic                             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        alloc_mode_next = alloc_mode_reg;
        slots_next      = slots_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                stffa_pkg::REG_ALLOC_MODE:   alloc_mode_next = pwdata[0];
                stffa_pkg::REG_SLOTS_IN_USE: slots_next = pwdata[stffa_pkg::SLOTS_W-1:0];
                default:                     alloc_mode_next = alloc_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_mode_reg <= 1'b0;
            slots_reg      <= stffa_pkg::SLOTS_RESET;
        end
        else
        begin
            alloc_mode_reg <= alloc_mode_next;
            slots_reg      <= slots_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            stffa_pkg::REG_ALLOC_MODE:
                prdata = {{(stffa_pkg::PDATA_W-1){1'b0}}, alloc_mode_reg};
            stffa_pkg::REG_SLOTS_IN_USE:
                prdata = {{(stffa_pkg::PDATA_W-stffa_pkg::SLOTS_W){1'b0}}, slots_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.alloc_mode   = alloc_mode_reg;
    assign cfg.slots_in_use = slots_reg;

endmodule

`default_nettype wire

/* rtl/stffa_engine.sv */
// Request sequencer: scans the slot table RAM, keeps the found list, drives results.
`default_nettype none

`include "slot_table_first_fit_allocator_core_macros.svh"

module stffa_engine #(
    parameter int NUM_SLOTS   = 256,
    parameter int MAX_REQUEST = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire stffa_pkg::cfg_t                cfg,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [stffa_pkg::REQ_W-1:0]    in_req,
    input  wire logic [stffa_pkg::OWNER_W-1:0]  in_owner,
    input  wire logic [stffa_pkg::COUNT_W-1:0]  in_count,
    input  wire logic [stffa_pkg::SIDX_W-1:0]   in_slot,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [stffa_pkg::STATUS_W-1:0]      out_status,
    output logic [stffa_pkg::GSLOT_W-1:0]       out_slot,
    output logic [stffa_pkg::RELCNT_W-1:0]      out_count,
    output logic                                out_last
);

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int SCAN_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W  = (SCAN_W > stffa_pkg::SLOTS_W) ? SCAN_W : stffa_pkg::SLOTS_W;
    localparam int FL_AW  = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
    localparam int POS_W  = $clog2(MAX_REQUEST + 1);
    localparam int OW     = stffa_pkg::OWNER_W;

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_SCAN     = 7'b0000100,
        ST_FL_RD    = 7'b0001000,
        ST_EMIT     = 7'b0010000,
        ST_REL_SLOT = 7'b0100000,
        ST_RESP     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [OW-1:0]                       owner_reg, owner_next;
    logic [POS_W-1:0]                    want_reg, want_next;
    logic                                op_alloc_reg, op_alloc_next;
    logic [SCAN_W-1:0]                   rd_idx_reg, rd_idx_next;
    logic                                chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]                    chk_idx_reg, chk_idx_next;
    logic [POS_W-1:0]                    pos_reg, pos_next;
    logic [stffa_pkg::RELCNT_W-1:0]      freed_reg, freed_next;
    logic [stffa_pkg::STATUS_W-1:0]      resp_status_reg, resp_status_next;
    logic [IDX_W-1:0]                    clr_idx_reg, clr_idx_next;

    logic                                out_valid_reg, out_valid_next;
    logic [stffa_pkg::STATUS_W-1:0]      out_status_reg, out_status_next;
    logic [stffa_pkg::GSLOT_W-1:0]       out_slot_reg, out_slot_next;
    logic [stffa_pkg::RELCNT_W-1:0]      out_count_reg, out_count_next;
    logic                                out_last_reg, out_last_next;
    logic                                out_load;
    logic                                out_free;

    logic                                tbl_we;
    logic [IDX_W-1:0]                    tbl_waddr;
    logic [OW-1:0]                       tbl_wdata;
    logic                                tbl_re;
    logic [IDX_W-1:0]                    tbl_raddr;
    logic [OW-1:0]                       tbl_rdata;

    logic                                fl_we;
    logic [FL_AW-1:0]                    fl_waddr;
    logic [IDX_W-1:0]                    fl_wdata;
    logic                                fl_re;
    logic [FL_AW-1:0]                    fl_raddr;
    logic [IDX_W-1:0]                    fl_rdata;

    logic [CMP_W-1:0]                    slots_ext;
    logic [CMP_W-1:0]                    n_size;
    logic [CMP_W-1:0]                    sidx_ext;
    logic [CMP_W-1:0]                    fl_slot_ext;
    logic [stffa_pkg::CNT_CMP_W-1:0]     count_ext;
    logic                                bad_alloc;
    logic                                issue;
    logic [POS_W-1:0]                    pos_inc;

    stffa_ram #(
        .WIDTH (OW),
        .DEPTH (NUM_SLOTS)
    ) u_owner_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    stffa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_REQUEST)
    ) u_found_list (
        .clk   (clk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .re    (fl_re),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    // Managed size is slots_in_use clipped to the table depth.
    assign slots_ext   = CMP_W'(cfg.slots_in_use);
    assign n_size      = (slots_ext > CMP_W'(NUM_SLOTS)) ? CMP_W'(NUM_SLOTS) : slots_ext;
    assign sidx_ext    = CMP_W'(in_slot);
    assign fl_slot_ext = CMP_W'(fl_rdata);
    assign count_ext   = stffa_pkg::CNT_CMP_W'(in_count);
    assign bad_alloc   = (in_owner == '0) || (in_count == '0)
                         || (count_ext > stffa_pkg::CNT_CMP_W'(MAX_REQUEST));
    assign issue       = CMP_W'(rd_idx_reg) < n_size;
    assign pos_inc     = pos_reg + POS_W'(1);
    assign out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        owner_next       = owner_reg;
        want_next        = want_reg;
        op_alloc_next    = op_alloc_reg;
        rd_idx_next      = rd_idx_reg;
        chk_valid_next   = chk_valid_reg;
        chk_idx_next     = chk_idx_reg;
        pos_next         = pos_reg;
        freed_next       = freed_reg;
        resp_status_next = resp_status_reg;
        clr_idx_next     = clr_idx_reg;

        out_load         = 1'b0;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;

        in_ready  = 1'b0;
        tbl_we    = 1'b0;
        tbl_waddr = '0;
        tbl_wdata = '0;
        tbl_re    = 1'b0;
        tbl_raddr = '0;
        fl_we     = 1'b0;
        fl_waddr  = '0;
        fl_wdata  = '0;
        fl_re     = 1'b0;
        fl_raddr  = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_we       = 1'b1;
                tbl_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(NUM_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    owner_next       = in_owner;
                    want_next        = count_ext[POS_W-1:0];
                    pos_next         = '0;
                    rd_idx_next      = '0;
                    chk_valid_next   = 1'b0;
                    chk_idx_next     = sidx_ext[IDX_W-1:0];
                    freed_next       = '0;
                    unique case (in_req)
                        stffa_pkg::REQ_ALLOC:
                        begin
                            op_alloc_next    = 1'b1;
                            resp_status_next = stffa_pkg::ST_FAIL;
                            state_next       = bad_alloc ? ST_RESP : ST_SCAN;
                        end
                        stffa_pkg::REQ_REL_OWNER:
                        begin
                            op_alloc_next    = 1'b0;
                            resp_status_next = stffa_pkg::ST_REL;
                            state_next       = (in_owner == '0) ? ST_RESP : ST_SCAN;
                        end
                        stffa_pkg::REQ_REL_SLOT:
                        begin
                            resp_status_next = stffa_pkg::ST_REL;
                            if (sidx_ext < n_size)
                            begin
                                tbl_re     = 1'b1;
                                tbl_raddr  = sidx_ext[IDX_W-1:0];
                                state_next = ST_REL_SLOT;
                            end
                            else
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        default:
                        begin
                            // drop the beat, no result
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // one read issued per cycle; its data is checked the cycle after
                tbl_re         = issue;
                tbl_raddr      = rd_idx_reg[IDX_W-1:0];
                chk_valid_next = issue;
                chk_idx_next   = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + SCAN_W'(1);
                end
                if (chk_valid_reg)
                begin
                    if (op_alloc_reg)
                    begin
                        if (tbl_rdata == '0)
                        begin
                            fl_we    = 1'b1;
                            fl_waddr = pos_reg[FL_AW-1:0];
                            fl_wdata = chk_idx_reg;
                            if (pos_inc == want_reg)
                            begin
                                pos_next   = '0;
                                state_next = ST_FL_RD;
                            end
                            else
                            begin
                                pos_next = pos_inc;
                            end
                        end
                        else if (cfg.alloc_mode)
                        begin
                            // restart the contiguous run
                            pos_next = '0;
                        end
                    end
                    else if (tbl_rdata == owner_reg)
                    begin
                        tbl_we    = 1'b1;
                        tbl_waddr = chk_idx_reg;
                        if (freed_reg != stffa_pkg::RELCNT_MAX)
                        begin
                            freed_next = freed_reg + stffa_pkg::RELCNT_W'(1);
                        end
                    end
                end
                else if (!issue)
                begin
                    state_next = ST_RESP;
                end
            end

            ST_FL_RD:
            begin
                fl_re      = 1'b1;
                fl_raddr   = pos_reg[FL_AW-1:0];
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = stffa_pkg::ST_GRANT;
                    out_slot_next   = fl_slot_ext[stffa_pkg::GSLOT_W-1:0];
                    out_count_next  = '0;
                    out_last_next   = (pos_inc == want_reg);
                    tbl_we          = 1'b1;
                    tbl_waddr       = fl_rdata;
                    tbl_wdata       = owner_reg;
                    if (pos_inc == want_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        state_next = ST_FL_RD;
                    end
                end
            end

            ST_REL_SLOT:
            begin
                if (tbl_rdata != '0)
                begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = chk_idx_reg;
                    freed_next = stffa_pkg::RELCNT_W'(1);
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = resp_status_reg;
                    out_slot_next   = '0;
                    out_count_next  = freed_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg       <= owner_next;
        want_reg        <= want_next;
        op_alloc_reg    <= op_alloc_next;
        rd_idx_reg      <= rd_idx_next;
        chk_idx_reg     <= chk_idx_next;
        pos_reg         <= pos_next;
        freed_reg       <= freed_next;
        resp_status_reg <= resp_status_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

    `STFFA_ASSERT_ALWAYS(a_reset_starts_clear, !rst_n |=> state_reg == ST_CLEAR, "clearing pass not started after reset")
    `STFFA_ASSERT(a_no_same_entry_rw, (tbl_we && tbl_re) |-> (tbl_waddr != tbl_raddr), "slot table read and write hit the same entry")
    `STFFA_ASSERT(a_pos_below_want, ((state_reg == ST_SCAN && op_alloc_reg) || state_reg == ST_EMIT) |-> (pos_reg < want_reg), "found list position beyond request size")
    `STFFA_ASSERT(a_one_request_at_once, (in_valid && in_ready && state_next != ST_IDLE) |=> !in_ready, "new request taken while one is in progress")
    `STFFA_ASSERT(a_last_returns_idle, (out_load && out_last_next) |=> state_reg == ST_IDLE, "final result did not end the request")

endmodule

`default_nettype wire
